// File: hdl/sorted_key_insert_table_assert.svh
// Assertion macros for the sorted key table.
// Simulation gets the checks. Synthesis gets empty bodies.
`ifndef SORTED_KEY_INSERT_TABLE_ASSERT_SVH
`define SORTED_KEY_INSERT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define SKIT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SKIT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SKIT_ASSERT(lbl, clk, rst_n, prop, msg)
`define SKIT_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hdl/skit_pkg.sv
`timescale 1ns / 1ps

package skit_pkg;

  // Operation codes.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_UNFILLED = 2'd2;

  // Cells per reduction group and the width of the index within a group.
  localparam int GROUP_SIZE = 16;
  localparam int LIDX_W     = 4;

  // Input request.
  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [7:0]         slot;
  } in_t;

  // Result.
  typedef struct packed {
    logic [1:0]         status;
    logic [8:0]         position;
    logic signed [31:0] key_out;
    logic [31:0]        payload_out;
    logic [8:0]         fill_count;
  } out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic               insert;
    logic               read;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [7:0]         slot;
  } cell_req_t;

  // What one cell hands to its upper neighbor.
  typedef struct packed {
    logic               less;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } cell_link_t;

  // Registered summary of one group of cells.
  typedef struct packed {
    logic               hit;
    logic [LIDX_W-1:0]  lidx;
    logic signed [31:0] key;
    logic [31:0]        payload;
  } grp_t;

endpackage

// File: hdl/skit_cell.sv
`timescale 1ns / 1ps

module skit_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9
) (
  input  logic                   clk_i,
  input  skit_pkg::cell_req_t    req_i,
  input  logic [CW-1:0]          count_i,
  input  skit_pkg::cell_link_t   prev_i,
  output skit_pkg::cell_link_t   link_o,
  output logic                   hot_o
);
  import skit_pkg::*;

  localparam int SW = (CW > 8) ? CW : 8;

  logic signed [31:0] key_q;
  logic [31:0]        payload_q;
  logic               filled;
  logic               less;
  logic               boundary;
  logic               slot_hit;

  // A filled cell below the request key is part of the lower prefix.
  assign filled   = CW'(IDX) < count_i;
  assign less     = filled && (key_q < req_i.key);
  assign boundary = prev_i.less && !less;
  assign slot_hit = SW'(req_i.slot) == SW'(IDX);

  assign link_o.less    = less;
  assign link_o.key     = key_q;
  assign link_o.payload = payload_q;

  // The first cell not below the key marks the lower-bound position.
  assign hot_o = req_i.read ? slot_hit : boundary;

  // On insert the boundary cell takes the new entry and every cell above it
  // takes its lower neighbor's entry.
  always_ff @(posedge clk_i) begin
    if (req_i.insert) begin
      if (boundary) begin
        key_q     <= req_i.key;
        payload_q <= req_i.payload;
      end else if (!prev_i.less) begin
        key_q     <= prev_i.key;
        payload_q <= prev_i.payload;
      end
    end
  end

endmodule

// File: hdl/skit_group.sv
`timescale 1ns / 1ps

module skit_group (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [skit_pkg::GROUP_SIZE-1:0]          hot_i,
  input  logic [skit_pkg::GROUP_SIZE-1:0][31:0]    key_i,
  input  logic [skit_pkg::GROUP_SIZE-1:0][31:0]    payload_i,
  output skit_pkg::grp_t                           grp_o
);
  import skit_pkg::*;

  grp_t grp_d;
  grp_t grp_q;

  // At most one cell of the chain is marked, so an OR merge selects it.
  always_comb begin
    grp_d = '0;
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (hot_i[i]) begin
        grp_d.hit     = 1'b1;
        grp_d.lidx    = grp_d.lidx | LIDX_W'(i);
        grp_d.key     = grp_d.key | key_i[i];
        grp_d.payload = grp_d.payload | payload_i[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grp_q <= grp_d;
    end
  end

  assign grp_o = grp_q;

endmodule

// File: hdl/sorted_key_insert_table.sv
// Sorted key table built as a chain of cells, one cell per entry.
// A request is compared and shifted in the cell chain, with the group summaries
// registered, then the registered groups are merged into the output register.
// The next request is taken as soon as the current one has reached the output
// register, so a new request is not taken while one is still in flight.
// Reset: asynchronous, active low; clears the entry count and handshake state.
`timescale 1ns / 1ps
`include "sorted_key_insert_table_assert.svh"

module sorted_key_insert_table #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  skit_pkg::in_t  in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output skit_pkg::out_t out_rsp_o
);
  import skit_pkg::*;

  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int NG  = (MAX_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;
  localparam int NC  = NG * GROUP_SIZE;
  localparam int SW  = (CW > 8) ? CW : 8;
  localparam int PW0 = (CW > GW + LIDX_W) ? CW : GW + LIDX_W;
  localparam int PW  = (PW0 > 9) ? PW0 : 9;

  // Control and request registers.
  in_t           req_q;
  logic          s1_v_q;
  logic          s2_v_q;
  logic          full_q;
  logic [CW-1:0] count_q;
  logic          out_v_q;
  out_t          out_q;
  out_t          out_d;

  logic          accept;
  logic          full;
  logic          out_load;
  cell_req_t     cell_req;

  assign accept   = in_valid_i && !in_stall_o;
  assign full     = count_q == CW'(MAX_ENTRIES);
  assign out_load = s2_v_q && (!out_v_q || !out_stall_i);

  assign in_stall_o  = s1_v_q || s2_v_q;
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  // Broadcast to the cells; the table changes only in the compare cycle.
  assign cell_req.insert  = s1_v_q && (req_q.op == OP_INSERT) && !full;
  assign cell_req.read    = req_q.op == OP_READ;
  assign cell_req.key     = req_q.key;
  assign cell_req.payload = req_q.payload;
  assign cell_req.slot    = req_q.slot;

  // Cell chain, padded with idle positions up to a whole number of groups.
  cell_link_t                 head;
  cell_link_t [MAX_ENTRIES-1:0] link;
  logic [NC-1:0]              hot;
  logic [NC-1:0][31:0]        cell_key;
  logic [NC-1:0][31:0]        cell_payload;

  assign head.less    = 1'b1;
  assign head.key     = '0;
  assign head.payload = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    if (i < MAX_ENTRIES) begin : g_live
      skit_cell #(
        .IDX (i),
        .CW  (CW)
      ) u_cell (
        .clk_i   (clk_i),
        .req_i   (cell_req),
        .count_i (count_q),
        .prev_i  ((i == 0) ? head : link[(i == 0) ? 0 : i - 1]),
        .link_o  (link[i]),
        .hot_o   (hot[i])
      );
      assign cell_key[i]     = link[i].key;
      assign cell_payload[i] = link[i].payload;
    end else begin : g_pad
      assign hot[i]          = 1'b0;
      assign cell_key[i]     = '0;
      assign cell_payload[i] = '0;
    end
  end

  // First level of the merge tree, registered in the compare cycle.
  grp_t [NG-1:0] grp;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    skit_group u_group (
      .clk_i     (clk_i),
      .en_i      (s1_v_q),
      .hot_i     (hot[g*GROUP_SIZE +: GROUP_SIZE]),
      .key_i     (cell_key[g*GROUP_SIZE +: GROUP_SIZE]),
      .payload_i (cell_payload[g*GROUP_SIZE +: GROUP_SIZE]),
      .grp_o     (grp[g])
    );
  end

  // Second level of the merge tree and result formatting.
  logic               any_hit;
  logic [GW-1:0]      gidx;
  logic [LIDX_W-1:0]  lidx;
  logic signed [31:0] sel_key;
  logic [31:0]        sel_payload;
  logic [PW-1:0]      pos;
  logic               slot_filled;

  always_comb begin
    any_hit     = 1'b0;
    gidx        = '0;
    lidx        = '0;
    sel_key     = '0;
    sel_payload = '0;
    for (int g = 0; g < NG; g++) begin
      if (grp[g].hit) begin
        any_hit     = 1'b1;
        gidx        = gidx | GW'(g);
        lidx        = lidx | grp[g].lidx;
        sel_key     = sel_key | grp[g].key;
        sel_payload = sel_payload | grp[g].payload;
      end
    end
  end

  // No boundary in the chain means a full table with every key below.
  assign pos = any_hit ? PW'({gidx, lidx}) : PW'(MAX_ENTRIES);
  assign slot_filled = SW'(req_q.slot) < SW'(count_q);

  always_comb begin
    out_d             = '0;
    out_d.fill_count  = 9'(PW'(count_q));
    unique case (req_q.op)
      OP_INSERT: begin
        out_d.position = pos[8:0];
        out_d.status   = full_q ? ST_FULL : ST_OK;
      end
      OP_FIND: begin
        out_d.position = pos[8:0];
      end
      OP_READ: begin
        out_d.position = 9'(req_q.slot);
        if (slot_filled) begin
          out_d.key_out     = sel_key;
          out_d.payload_out = sel_payload;
        end else begin
          out_d.status = ST_UNFILLED;
        end
      end
      default: begin
        out_d.position = '0;
      end
    endcase
  end

  // Request register, output register and sequencing.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (s1_v_q) begin
      full_q <= full;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_v_q) begin
        s1_v_q <= 1'b0;
      end
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (out_load) begin
        s2_v_q <= 1'b0;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (cell_req.insert) begin
        count_q <= count_q + CW'(1);
      end
    end
  end

  // Checks.
  `SKIT_ASSERT(a_stage_excl, clk_i, rst_ni, !(s1_v_q && s2_v_q), "both stages busy")
  `SKIT_ASSERT(a_s1_to_s2, clk_i, rst_ni, s1_v_q |=> s2_v_q, "compare result lost")
  `SKIT_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CW'(MAX_ENTRIES), "count overflow")
  `SKIT_ASSERT(a_count_inc, clk_i, rst_ni,
               cell_req.insert |=> count_q == $past(count_q) + CW'(1), "insert not counted")
  `SKIT_ASSERT(a_out_src, clk_i, rst_ni, $rose(out_v_q) |-> $past(s2_v_q), "result without request")

endmodule

// File: sim/sorted_key_insert_table_check.sv
`timescale 1ns / 1ps

// Watches both channels of the sorted key table, keeps its own sorted copy of
// the table and compares every result against the oldest predicted one.
module sorted_key_insert_table_check #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  skit_pkg::in_t  in_req_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  skit_pkg::out_t out_rsp_i,
  output int             mismatch_count_o,
  output int             pending_o
);
  import skit_pkg::*;

  // Shadow copy of the table, kept sorted ascending by signed key.
  logic signed [31:0] shadow_key     [MAX_ENTRIES];
  logic [31:0]        shadow_payload [MAX_ENTRIES];
  int unsigned        shadow_count;

  // Results predicted for accepted requests, oldest first.
  out_t expected_rsp_q [$];

  // First slot whose key is greater than or equal to k.
  function automatic int unsigned lower_bound_slot(logic signed [31:0] k);
    int unsigned pos;
    pos = 0;
    while (pos < shadow_count && shadow_key[pos] < k) pos++;
    return pos;
  endfunction

  // Applies one request to the shadow table and returns the result it gives.
  function automatic out_t apply_request(in_t req);
    out_t        rsp;
    int unsigned pos;
    int unsigned j;
    rsp = '0;
    case (req.op)
      OP_INSERT: begin
        pos = lower_bound_slot(req.key);
        rsp.position = pos[8:0];
        if (shadow_count >= MAX_ENTRIES) begin
          rsp.status = ST_FULL;
        end else begin
          // Open a gap at the insertion slot by moving later entries up.
          for (j = shadow_count; j > pos; j--) begin
            shadow_key[j]     = shadow_key[j-1];
            shadow_payload[j] = shadow_payload[j-1];
          end
          shadow_key[pos]     = req.key;
          shadow_payload[pos] = req.payload;
          shadow_count++;
        end
      end
      OP_FIND: begin
        pos = lower_bound_slot(req.key);
        rsp.position = pos[8:0];
      end
      OP_READ: begin
        rsp.position = {1'b0, req.slot};
        if (req.slot < shadow_count && req.slot < MAX_ENTRIES) begin
          rsp.key_out     = shadow_key[req.slot];
          rsp.payload_out = shadow_payload[req.slot];
        end else begin
          rsp.status = ST_UNFILLED;
        end
      end
      default: begin
        // The unused op code leaves the table alone and reports zeros.
      end
    endcase
    rsp.fill_count = shadow_count[8:0];
    return rsp;
  endfunction

  // Counts a failure; only the first ten are printed.
  task automatic report_failure(string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      report_failure($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
    end
  endtask

  // Result side is handled before the request side of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      shadow_count     = 0;
      mismatch_count_o = 0;
      expected_rsp_q.delete();
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_failure($sformatf("result %p with no request outstanding", out_rsp_i));
        end else begin
          want = expected_rsp_q.pop_front();
          compare_field("status", 32'(want.status), 32'(out_rsp_i.status));
          compare_field("position", 32'(want.position), 32'(out_rsp_i.position));
          compare_field("key_out", want.key_out, out_rsp_i.key_out);
          compare_field("payload_out", want.payload_out, out_rsp_i.payload_out);
          compare_field("fill_count", 32'(want.fill_count), 32'(out_rsp_i.fill_count));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rsp_q.push_back(apply_request(in_req_i));
      end
      pending_o = expected_rsp_q.size();
    end
  end

endmodule

// File: sim/sorted_key_insert_table_test.sv
`timescale 1ns / 1ps

// Drives requests into the sorted key table and gives the verdict.
module sorted_key_insert_table_test;
  import skit_pkg::*;

  localparam int TABLE_DEPTH     = 256;
  localparam int RANDOM_REQUESTS = 1880;
  localparam int FILL_REQUESTS   = 600;
  localparam int QUIET_FIRST     = 700;
  localparam int QUIET_LAST      = 1000;
  localparam int HOLD_AT         = 1200;
  localparam int HOLD_CYCLES     = 400;
  localparam int IDLE_LIMIT      = 3000;

  // The op code that the block does not define.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_rsp;

  int mismatches;
  int pending;
  int idle_cycles = 0;
  bit quiet_stretch = 1'b0;
  bit hold_request = 1'b0;

  always #4 clk = ~clk;

  sorted_key_insert_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  sorted_key_insert_table_check #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_rsp_i       (out_rsp),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  function automatic in_t make_request(logic [1:0] op, logic signed [31:0] key,
                                       logic [31:0] payload, logic [7:0] slot);
    in_t req;
    req.op      = op;
    req.key     = key;
    req.payload = payload;
    req.slot    = slot;
    return req;
  endfunction

  // Keys mix full range values, extremes and a small set that repeats often.
  function automatic logic signed [31:0] pick_key();
    logic signed [31:0] k;
    case ($urandom_range(0, 3))
      0: k = $urandom;
      1: k = (int'($urandom_range(0, 15)) - 8) <<< 16;
      2: begin
        case ($urandom_range(0, 4))
          0: k = KEY_MIN;
          1: k = KEY_MAX;
          2: k = 32'sd0;
          3: k = -32'sd1;
          default: k = 32'sd1;
        endcase
      end
      default: k = int'($urandom_range(0, 255)) - 128;
    endcase
    return k;
  endfunction

  // Inserts dominate while the table fills, then finds and reads take over.
  function automatic logic [1:0] pick_op(int idx);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return OP_UNUSED;
    if (roll < ((idx < FILL_REQUESTS) ? 59 : 34)) return OP_INSERT;
    if (roll < ((idx < FILL_REQUESTS) ? 80 : 67)) return OP_FIND;
    return OP_READ;
  endfunction

  // Offers one request, with random idle cycles ahead of it, until accepted.
  task automatic send_request(in_t req);
    while (!quiet_stretch && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off that backs the block up.
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_request && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet_stretch && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timeout after %0d cycles without progress", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    in_t req;
    int  i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: a find lands at slot zero, reads are unfilled, then the unused op code.
    send_request(make_request(OP_FIND, 32'sd0, 32'h0, 8'd0));
    send_request(make_request(OP_READ, 32'sd0, 32'h0, 8'd0));
    send_request(make_request(OP_READ, KEY_MAX, 32'hFFFF_FFFF, 8'd255));
    send_request(make_request(OP_UNUSED, KEY_MIN, 32'hFFFF_FFFF, 8'd255));

    // Inserts of extreme keys and payloads, equal keys and keys around zero, then finds.
    send_request(make_request(OP_INSERT, KEY_MAX, 32'hFFFF_FFFF, 8'd255));
    send_request(make_request(OP_INSERT, KEY_MIN, 32'h0000_0000, 8'd0));
    send_request(make_request(OP_INSERT, 32'sd0, 32'h1234_5678, 8'd0));
    send_request(make_request(OP_INSERT, 32'sd0, 32'h8765_4321, 8'd0));
    send_request(make_request(OP_INSERT, -32'sd1, 32'hA5A5_A5A5, 8'd0));
    send_request(make_request(OP_INSERT, 32'sd1, 32'h5A5A_5A5A, 8'd0));
    send_request(make_request(OP_FIND, KEY_MIN, 32'h0, 8'd0));
    send_request(make_request(OP_FIND, KEY_MAX, 32'h0, 8'd0));
    send_request(make_request(OP_FIND, 32'sd0, 32'h0, 8'd0));
    send_request(make_request(OP_FIND, 32'sh0001_0000, 32'h0, 8'd0));

    // Read back every filled slot and the first slot past the end.
    for (i = 0; i <= 6; i++) begin
      send_request(make_request(OP_READ, 32'sd0, 32'h0, 8'(i)));
    end
    send_request(make_request(OP_UNUSED, pick_key(), $urandom, 8'($urandom)));

    // Random part; the table fills early and then stays full.
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      quiet_stretch = (i >= QUIET_FIRST && i < QUIET_LAST);
      if (i == HOLD_AT) hold_request = 1'b1;
      req.op      = pick_op(i);
      req.key     = pick_key();
      req.payload = $urandom;
      req.slot    = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(0, 15));
      send_request(req);
    end
    in_valid <= 1'b0;

    // Drain, then wait for anything stray to show up.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
